>>> design/hcmc_pkg.sv
// hcmc_pkg: shared widths, register indexes, reset values and the frame summary
// record passed from the pixel front end to the centroid divider.
// No dependencies.
`timescale 1ns / 1ps
package hcmc_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  localparam int PosW   = 12;   // column / row position
  localparam int DimW   = 13;   // window size registers
  localparam int HitW   = 25;   // match count, saturates at 2^24
  localparam int SumW   = 36;   // column / row sums
  localparam int HalfW  = 12;   // rounded half of window size
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 13;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_HUE_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HUE_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SAT_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SAT_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VAL_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VAL_MAX = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_WIDTH   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT  = 3'd7;

  localparam logic [7:0] HUE_MIN_RST = 8'd145;
  localparam logic [7:0] HUE_MAX_RST = 8'd160;
  localparam logic [7:0] SAT_MIN_RST = 8'd95;
  localparam logic [7:0] SAT_MAX_RST = 8'd255;
  localparam logic [7:0] VAL_MIN_RST = 8'd65;
  localparam logic [7:0] VAL_MAX_RST = 8'd200;
  localparam logic [DimW-1:0] WIDTH_RST  = 13'd576;
  localparam logic [DimW-1:0] HEIGHT_RST = 13'd324;

  // summary of one finished frame
  typedef struct packed {
    logic [HitW-1:0]  hits;
    logic [SumW-1:0]  col_sum;
    logic [SumW-1:0]  row_sum;
    logic [HalfW-1:0] half_w;
    logic [HalfW-1:0] half_h;
  } frame_sum_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> design/hcmc_pixel_if.sv
// hcmc_pixel_if: valid/ready channel carrying one BGR pixel and its frame mark.
// No dependencies.
`timescale 1ns / 1ps
interface hcmc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       frame_end;

  modport source (output valid, blue, green, red, frame_end, input ready);
  modport sink   (input valid, blue, green, red, frame_end, output ready);
endinterface

>>> design/hcmc_result_if.sv
// hcmc_result_if: valid/ready channel carrying one frame centroid result.
// No dependencies.
`timescale 1ns / 1ps
interface hcmc_result_if;
  logic               valid;
  logic               ready;
  logic               target_found;
  logic signed [12:0] offset_x;
  logic signed [12:0] offset_y;
  logic [24:0]        match_total;

  modport source (output valid, target_found, offset_x, offset_y, match_total,
                  input ready);
  modport sink   (input valid, target_found, offset_x, offset_y, match_total,
                  output ready);
endinterface

>>> design/hcmc_front.sv
// hcmc_front: configuration registers, BGR to HSV pipeline, threshold match and
// per-frame accumulation. Depends on hcmc_pkg and hcmc_pixel_if.
`timescale 1ns / 1ps
module hcmc_front
  import hcmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  hcmc_pixel_if.sink          pixel,
  input  queue_status_t       q_status,
  output logic                q_push,
  output frame_sum_t          q_data
);

  logic [7:0] hue_min, hue_max, sat_min, sat_max, val_min, val_max;
  logic [DimW-1:0] window_width, window_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_min <= HUE_MIN_RST;
      hue_max <= HUE_MAX_RST;
      sat_min <= SAT_MIN_RST;
      sat_max <= SAT_MAX_RST;
      val_min <= VAL_MIN_RST;
      val_max <= VAL_MAX_RST;
      window_width  <= WIDTH_RST;
      window_height <= HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HUE_MIN: hue_min <= cfg_data[7:0];
        REG_HUE_MAX: hue_max <= cfg_data[7:0];
        REG_SAT_MIN: sat_min <= cfg_data[7:0];
        REG_SAT_MAX: sat_max <= cfg_data[7:0];
        REG_VAL_MIN: val_min <= cfg_data[7:0];
        REG_VAL_MAX: val_max <= cfg_data[7:0];
        REG_WIDTH:   window_width  <= cfg_data;
        REG_HEIGHT:  window_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // reciprocal tables, 12 fraction bits, rounded half up
  logic [19:0] srec_tab [256];
  logic [16:0] hrec_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam int unsigned Div  = (i == 0) ? 2 : 2 * i;
    localparam int unsigned Srec = (2 * 1044480 + i) / Div;
    localparam int unsigned Hrec = (i == 0) ? 0 : (245760 + i) / Div;
    assign srec_tab[i] = Srec[19:0];
    assign hrec_tab[i] = Hrec[16:0];
  end

  // stall only when a frame summary cannot enter the queue
  logic adv;
  logic s4_valid, s4_last, s4_match;
  assign adv = !(s4_valid && s4_last && q_status.full);
  assign pixel.ready = adv;

  // stage 1: max, min, hue numerator
  logic [7:0] mx, mn;
  logic signed [11:0] hn;
  always_comb begin
    mx = pixel.blue;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.red > mx)   mx = pixel.red;
    mn = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.red < mn)   mn = pixel.red;
    if (mx == pixel.red)
      hn = $signed({4'd0, pixel.green}) - $signed({4'd0, pixel.blue});
    else if (mx == pixel.green)
      hn = $signed({4'd0, pixel.blue}) - $signed({4'd0, pixel.red})
         + $signed({3'd0, mx - mn, 1'b0});
    else
      hn = $signed({4'd0, pixel.red}) - $signed({4'd0, pixel.green})
         + $signed({2'd0, mx - mn, 2'b0});
  end

  logic s1_valid, s1_last;
  logic [7:0] s1_v, s1_diff;
  logic signed [11:0] s1_hn;
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= pixel.valid;
    if (adv) begin
      s1_last <= pixel.frame_end;
      s1_v    <= mx;
      s1_diff <= mx - mn;
      s1_hn   <= hn;
    end
  end

  // stage 2: table lookups
  logic s2_valid, s2_last;
  logic [7:0] s2_v, s2_diff;
  logic signed [11:0] s2_hn;
  logic [19:0] s2_srec;
  logic [16:0] s2_hrec;
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
    if (adv) begin
      s2_last <= s1_last;
      s2_v    <= s1_v;
      s2_diff <= s1_diff;
      s2_hn   <= s1_hn;
      s2_srec <= srec_tab[s1_v];
      s2_hrec <= hrec_tab[s1_diff];
    end
  end

  // stage 3: the two reciprocal products
  logic s3_valid, s3_last;
  logic [7:0] s3_v;
  logic [27:0] s3_sprod;
  logic signed [29:0] s3_hprod;
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= s2_valid;
    if (adv) begin
      s3_last  <= s2_last;
      s3_v     <= s2_v;
      s3_sprod <= s2_diff * s2_srec;
      s3_hprod <= s2_hn * $signed({1'b0, s2_hrec});
    end
  end

  // stage 4: round, wrap hue, compare against bounds
  logic [28:0] s_full;
  logic [16:0] sat;
  logic signed [31:0] hu;
  logic signed [10:0] hue;
  logic match;
  always_comb begin
    s_full = {1'b0, s3_sprod} + 29'd2048;
    sat    = s_full[28:12];
    hu     = 32'(s3_hprod) + 32'sd1050624;
    hue    = $signed({1'b0, hu[21:12]}) - 11'sd256;
    if (hue < 11'sd0) hue = hue + 11'sd180;
    match  = (hue >= $signed({3'd0, hue_min})) && (hue <= $signed({3'd0, hue_max}))
          && (sat >= {9'd0, sat_min}) && (sat <= {9'd0, sat_max})
          && (s3_v >= val_min) && (s3_v <= val_max);
  end

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (adv) s4_valid <= s3_valid;
    if (adv) begin
      s4_last  <= s3_last;
      s4_match <= match;
    end
  end

  // stage 5: position tracking and accumulation
  logic [DimW-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = window_width;
    if (window_width == '0) w_eff = DimW'(1);
    else if (window_width > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
    h_eff = window_height;
    if (window_height == '0) h_eff = DimW'(1);
    else if (window_height > DimW'(MaxHeight)) h_eff = DimW'(MaxHeight);
  end

  logic [PosW-1:0] col, row;
  logic [HitW-1:0] hits;
  logic [SumW-1:0] col_sum, row_sum;
  logic take;
  logic [HitW-1:0] hits_next;
  logic [SumW-1:0] col_sum_next, row_sum_next;
  logic [DimW-1:0] col_inc, row_inc, w_round, h_round;

  always_comb begin
    take         = s4_match && !hits[HitW-1];
    hits_next    = take ? hits + HitW'(1) : hits;
    col_sum_next = take ? col_sum + SumW'(col) : col_sum;
    row_sum_next = take ? row_sum + SumW'(row) : row_sum;
    col_inc      = {1'b0, col} + DimW'(1);
    row_inc      = {1'b0, row} + DimW'(1);
    w_round      = w_eff + DimW'(1);
    h_round      = h_eff + DimW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      hits <= '0;
      col_sum <= '0;
      row_sum <= '0;
    end else if (adv && s4_valid) begin
      if (s4_last) begin
        col <= '0;
        row <= '0;
        hits <= '0;
        col_sum <= '0;
        row_sum <= '0;
      end else begin
        hits    <= hits_next;
        col_sum <= col_sum_next;
        row_sum <= row_sum_next;
        if (col_inc >= w_eff) begin
          col <= '0;
          row <= (row_inc >= h_eff) ? '0 : row_inc[PosW-1:0];
        end else begin
          col <= col_inc[PosW-1:0];
        end
      end
    end
  end

  assign q_push = adv && s4_valid && s4_last;
  always_comb begin
    q_data.hits    = hits_next;
    q_data.col_sum = col_sum_next;
    q_data.row_sum = row_sum_next;
    q_data.half_w  = w_round[DimW-1:1];
    q_data.half_h  = h_round[DimW-1:1];
  end

endmodule

>>> design/hcmc_queue.sv
// hcmc_queue: two-entry queue of frame summaries between front and back.
// Depends on hcmc_pkg.
`timescale 1ns / 1ps
module hcmc_queue
  import hcmc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_sum_t    push_data,
  input  logic          pop,
  output frame_sum_t    head,
  output queue_status_t status
);

  frame_sum_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;

endmodule

>>> design/hcmc_back.sv
// hcmc_back: restoring divider for the rounded mean column and row, offset
// subtraction and the result output register. Depends on hcmc_pkg, hcmc_result_if.
`timescale 1ns / 1ps
module hcmc_back
  import hcmc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  frame_sum_t    head,
  input  queue_status_t q_status,
  output logic          q_pop,
  output logic          busy,
  hcmc_result_if.source result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;
  localparam int NumW = SumW + 2;

  logic [1:0] state;
  logic [3:0] step;
  logic [NumW-1:0] rem_x, rem_y, dshift;
  logic [PosW-1:0] qx, qy;
  logic load;

  assign busy  = state == ST_DIV;
  assign load  = (state == ST_HOLD) && (!result.valid || result.ready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: if (!q_status.empty) begin
          state <= ST_DIV;
          step  <= 4'(PosW - 1);
        end
        ST_DIV: begin
          if (step == '0) state <= ST_HOLD;
          else step <= step - 4'd1;
        end
        ST_HOLD: if (load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // one quotient bit per cycle for both axes
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rem_x  <= {head.col_sum, 1'b0} + NumW'(head.hits);
      rem_y  <= {head.row_sum, 1'b0} + NumW'(head.hits);
      dshift <= NumW'({head.hits, 1'b0}) << (PosW - 1);
      qx <= '0;
      qy <= '0;
    end else if (state == ST_DIV) begin
      if (rem_x >= dshift) begin
        rem_x <= rem_x - dshift;
        qx    <= {qx[PosW-2:0], 1'b1};
      end else begin
        qx    <= {qx[PosW-2:0], 1'b0};
      end
      if (rem_y >= dshift) begin
        rem_y <= rem_y - dshift;
        qy    <= {qy[PosW-2:0], 1'b1};
      end else begin
        qy    <= {qy[PosW-2:0], 1'b0};
      end
      dshift <= dshift >> 1;
    end
  end

  logic found;
  assign found = head.hits != '0;

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (load) result.valid <= 1'b1;
    else if (result.ready) result.valid <= 1'b0;
    if (load) begin
      result.target_found <= found;
      result.match_total  <= head.hits;
      result.offset_x <= found ? $signed({1'b0, qx} - {1'b0, head.half_w}) : '0;
      result.offset_y <= found ? $signed({1'b0, qy} - {1'b0, head.half_h}) : '0;
    end
  end

endmodule

>>> design/hsv_color_mask_centroid_unit.sv
// hsv_color_mask_centroid_unit: top level of the color mask centroid finder.
// Depends on hcmc_pkg, hcmc_pixel_if, hcmc_result_if, hcmc_front, hcmc_queue, hcmc_back.
`timescale 1ns / 1ps
// Pixels arrive in raster order as 8-bit BGR and are taken one per clock: a
// five-stage front pipeline converts each to HSV (hue 0..179) with reciprocal
// tables, checks it against the inclusive H/S/V bounds and accumulates the
// match count and column/row sums. The pixel marked frame_end closes the frame
// and its summary enters a two-entry queue. The back end divides the sums by
// the count with a restoring divider that yields one quotient bit per clock
// and works on one summary at a time. With an idle back end, a summary passes
// the four front pipeline registers, the queue push, the load into the divider
// and the twelve quotient bits before its result becomes valid; the back end
// starts on a new summary only once it has moved the last result into its
// output register. The front keeps taking pixels meanwhile and stalls only
// when two finished frames already wait in the queue. Offsets are the rounded
// mean position minus the rounded half of the window size; a frame with no
// match reports all zeros. Configuration writes take effect at once and should
// land while the block is empty.
module hsv_color_mask_centroid_unit
  import hcmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  hcmc_pixel_if.sink          pixel,
  hcmc_result_if.source       result
);

  queue_status_t q_status;
  frame_sum_t    q_in, q_head;
  logic          q_push, q_pop, back_busy;

  // front: thresholds, HSV pipeline and accumulators
  hcmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // hold finished frame summaries until the divider is free
  hcmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // back: centroid division and result register
  hcmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .busy     (back_busy),
    .result   (result)
  );

  // never push a summary into a full queue unless one leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full && !q_pop))
    else $error("frame summary pushed into full queue");

  // the divider only runs on a queued summary
  a_div_has_entry: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> !q_status.empty)
    else $error("divider running with empty queue");

  // found flag agrees with the reported count
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.target_found == (result.match_total != '0)))
    else $error("target_found disagrees with match_total");

  // a frame without matches reports zero offsets
  a_zero_offsets: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.target_found) |->
      (result.offset_x == '0 && result.offset_y == '0))
    else $error("nonzero offset without a match");

endmodule
